// ===== hdl/lfspd_pkg.sv =====
// Shared types, widths and constants for the line-follow steering PD core.
// No dependencies; used by lfspd_cfg_regs and line_follow_steering_pd_core.
package lfspd_pkg;

    localparam int SENSOR_W       = 8;
    localparam int POS_W          = 11;  // weighted position, +-455 fits
    localparam int DIFF_W         = 12;  // position change
    localparam int GAIN_W         = 12;  // Q4.8 gains
    localparam int GAIN_FRAC_BITS = 8;
    localparam int PP_W           = POS_W + GAIN_W;
    localparam int PD_W           = DIFF_W + GAIN_W;
    localparam int SUM_W          = PD_W + 1;
    localparam int DRV_W          = 16;
    localparam int LIM_W          = 15;
    localparam int TICK_W         = 16;
    localparam int LOST_W         = 17;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int STAGES         = 6;

    localparam logic [SENSOR_W-1:0] ALL_SENSORS = 8'hFF;
    localparam logic signed [POS_W-1:0] DEAD_BAND = 11'sd3;
    localparam logic [LOST_W-1:0] LOST_SAT = '1;

    // Bit 0 is the leftmost sensor, bit 7 the rightmost.
    localparam logic signed [POS_W-1:0] SENSOR_WEIGHT [SENSOR_W] = '{
        11'sd200, 11'sd140, 11'sd75, 11'sd40,
        -11'sd40, -11'sd75, -11'sd140, -11'sd200
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP        = 3'd0,
        CFG_KD        = 3'd1,
        CFG_BASE      = 3'd2,
        CFG_LIMIT     = 3'd3,
        CFG_DRV_MAX   = 3'd4,
        CFG_DRV_MIN   = 3'd5,
        CFG_SLEW      = 3'd6,
        CFG_LOST_TICK = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] kd;
        logic signed [DRV_W-1:0]  base_drive;
        logic [LIM_W-1:0]         steer_limit;
        logic signed [DRV_W-1:0]  drive_max;
        logic signed [DRV_W-1:0]  drive_min;
        logic [LIM_W-1:0]         slew_step;
        logic [TICK_W-1:0]        lost_ticks;
    } t_cfg;

endpackage

// ===== hdl/line_follow_steering_pd_core.sv =====
// Top level of the line-follow steering PD core: six-stage pipeline.
// Depends on lfspd_pkg and lfspd_cfg_regs.
//
// Line-following steering controller. Each input beat carries one 8-bit
// line-sensor word and yields exactly one result beat with both wheel drives,
// the applied steer, a line-seen flag and a stop request. The sensors are
// weighted into a position, a small dead band is zeroed, and a PD law with
// Q4.8 gains (truncated toward zero) gives the negated steer, which is then
// limited in magnitude and in change per beat. A lost line (no sensor or all
// sensors set) holds the last steer until the lost count passes lost_ticks,
// after which steer is zero and stop is raised. Throughput is one beat per
// cycle while the output is not stalled; an accepted beat passes registered
// through stages 0 to 5 in order, and o_valid marks it in stage 5. The only
// beat-to-beat dependencies are the previous position (stage 1) and the
// previous steer and lost count (stage 4), each closed within one stage.
// Stages drain independently, so empty stages fill while a result is stalled
// at the output. Write configuration only while the pipeline is empty.
module line_follow_steering_pd_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sensor input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [lfspd_pkg::SENSOR_W-1:0]        i_sensor_bits,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [lfspd_pkg::DRV_W-1:0]    o_left_drive,
    output logic signed [lfspd_pkg::DRV_W-1:0]    o_right_drive,
    output logic signed [lfspd_pkg::DRV_W-1:0]    o_steer_out,
    output logic                                  o_line_seen,
    output logic                                  o_stop_request,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lfspd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lfspd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int NS = lfspd_pkg::STAGES;
    localparam int PW = lfspd_pkg::POS_W;
    localparam int DW = lfspd_pkg::DRV_W;
    localparam int SW = lfspd_pkg::SUM_W;

    lfspd_pkg::t_cfg cfg;

    lfspd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage advances when the next one is empty
    // or advancing itself. The output register advances when not stalled.
    // ------------------------------------------------------------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] mv;
    logic          ld;

    always_comb begin
        mv[NS-1] = r_v[NS-1] && !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            mv[k] = r_v[k] && (!r_v[k+1] || mv[k+1]);
        end
    end

    assign o_stall = r_v[0] && !mv[0];
    assign ld      = i_valid && !o_stall;

    always_comb begin
        n_v[0] = ld || (r_v[0] && !mv[0]);
        for (int k = 1; k < NS; k++) begin
            n_v[k] = mv[k-1] || (r_v[k] && !mv[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture the sensor word.
    // ------------------------------------------------------------------
    logic [lfspd_pkg::SENSOR_W-1:0] r_s0_bits;

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_s0_bits <= i_sensor_bits;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: weighted position, dead band, position change.
    // Previous position closes its loop here.
    // ------------------------------------------------------------------
    logic signed [PW-1:0]                   pos_raw;
    logic signed [PW-1:0]                   pos_dz;
    logic                                   seen0;
    logic signed [PW-1:0]                   r_prev_pos;
    logic signed [PW-1:0]                   r_s1_pos;
    logic signed [lfspd_pkg::DIFF_W-1:0]    r_s1_diff;
    logic                                   r_s1_seen;

    always_comb begin
        pos_raw = '0;
        for (int i = 0; i < lfspd_pkg::SENSOR_W; i++) begin
            if (r_s0_bits[i]) begin
                pos_raw = pos_raw + lfspd_pkg::SENSOR_WEIGHT[i];
            end
        end
    end

    assign pos_dz = (pos_raw > -lfspd_pkg::DEAD_BAND && pos_raw < lfspd_pkg::DEAD_BAND)
                    ? '0 : pos_raw;
    assign seen0  = (r_s0_bits != '0) && (r_s0_bits != lfspd_pkg::ALL_SENSORS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pos <= '0;
        end else if (mv[0]) begin
            // lost line forgets the position
            r_prev_pos <= seen0 ? pos_dz : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[0]) begin
            r_s1_pos  <= pos_dz;
            r_s1_diff <= lfspd_pkg::DIFF_W'(pos_dz) - lfspd_pkg::DIFF_W'(r_prev_pos);
            r_s1_seen <= seen0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: proportional and derivative products.
    // ------------------------------------------------------------------
    logic signed [lfspd_pkg::PP_W-1:0] r_s2_pp;
    logic signed [lfspd_pkg::PD_W-1:0] r_s2_pd;
    logic                              r_s2_seen;

    always_ff @(posedge i_clk) begin
        if (mv[1]) begin
            r_s2_pp   <= $signed(r_s1_pos) * $signed(cfg.kp);
            r_s2_pd   <= $signed(r_s1_diff) * $signed(cfg.kd);
            r_s2_seen <= r_s1_seen;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum, truncate toward zero, negate, magnitude limit.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] pd_sum;
    logic [SW-1:0]        pd_mag;
    logic [SW-1:0]        pd_q;
    logic [SW-1:0]        lim_ext;
    logic [SW-1:0]        q_lim;
    logic signed [DW-1:0] steer_lim;
    logic signed [DW-1:0] r_s3_steer;
    logic                 r_s3_seen;

    assign pd_sum  = SW'(r_s2_pp) + SW'(r_s2_pd);
    assign pd_mag  = pd_sum[SW-1] ? SW'(-pd_sum) : SW'(pd_sum);
    assign pd_q    = pd_mag >> lfspd_pkg::GAIN_FRAC_BITS;
    assign lim_ext = SW'(cfg.steer_limit);
    assign q_lim   = (pd_q > lim_ext) ? lim_ext : pd_q;
    // steer opposes the error: negative sum steers positive
    assign steer_lim = pd_sum[SW-1] ? $signed(q_lim[DW-1:0]) : -$signed(q_lim[DW-1:0]);

    always_ff @(posedge i_clk) begin
        if (mv[2]) begin
            r_s3_steer <= steer_lim;
            r_s3_seen  <= r_s2_seen;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: slew limit and lost-line handling. Previous steer and the
    // lost count close their loops here.
    // ------------------------------------------------------------------
    logic signed [DW:0]              slew_diff;
    logic signed [DW:0]              slew_ext;
    logic signed [DW:0]              prev_up;
    logic signed [DW:0]              prev_dn;
    logic signed [DW-1:0]            steer_slew;
    logic [lfspd_pkg::LOST_W-1:0]    lost_inc;
    logic                            lost_stop;
    logic signed [DW-1:0]            steer4;
    logic signed [DW-1:0]            r_prev_steer;
    logic [lfspd_pkg::LOST_W-1:0]    r_lost_cnt;
    logic signed [DW-1:0]            r_s4_steer;
    logic                            r_s4_seen;
    logic                            r_s4_stop;

    assign slew_diff = (DW+1)'(r_s3_steer) - (DW+1)'(r_prev_steer);
    assign slew_ext  = $signed({2'b00, cfg.slew_step});
    assign prev_up   = (DW+1)'(r_prev_steer) + slew_ext;
    assign prev_dn   = (DW+1)'(r_prev_steer) - slew_ext;

    always_comb begin
        if (slew_diff > slew_ext) begin
            steer_slew = prev_up[DW-1:0];
        end else if (slew_diff < -slew_ext) begin
            steer_slew = prev_dn[DW-1:0];
        end else begin
            steer_slew = r_s3_steer;
        end
    end

    assign lost_inc  = (r_lost_cnt == lfspd_pkg::LOST_SAT) ? r_lost_cnt : r_lost_cnt + 1'b1;
    assign lost_stop = !r_s3_seen && (lost_inc > lfspd_pkg::LOST_W'(cfg.lost_ticks));

    always_comb begin
        if (r_s3_seen) begin
            steer4 = steer_slew;
        end else if (lost_stop) begin
            steer4 = '0;
        end else begin
            steer4 = r_prev_steer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_steer <= '0;
            r_lost_cnt   <= '0;
        end else if (mv[3]) begin
            if (r_s3_seen) begin
                r_prev_steer <= steer_slew;
                r_lost_cnt   <= '0;
            end else begin
                // hold previous steer for slewing once the line returns
                r_lost_cnt <= lost_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[3]) begin
            r_s4_steer <= steer4;
            r_s4_seen  <= r_s3_seen;
            r_s4_stop  <= lost_stop;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: wheel drives, clamped; this is the output register.
    // An inverted range gives drive_max above drive_max and drive_min otherwise.
    // ------------------------------------------------------------------
    logic signed [DW:0]   left_sum;
    logic signed [DW:0]   right_sum;
    logic signed [DW:0]   dmax_ext;
    logic signed [DW:0]   dmin_ext;
    logic signed [DW-1:0] left_clamp;
    logic signed [DW-1:0] right_clamp;

    logic signed [DW-1:0] r_left;
    logic signed [DW-1:0] r_right;
    logic signed [DW-1:0] r_steer;
    logic                 r_seen;
    logic                 r_stop;

    assign left_sum  = (DW+1)'(cfg.base_drive) + (DW+1)'(r_s4_steer);
    assign right_sum = (DW+1)'(cfg.base_drive) - (DW+1)'(r_s4_steer);
    assign dmax_ext  = (DW+1)'(cfg.drive_max);
    assign dmin_ext  = (DW+1)'(cfg.drive_min);

    always_comb begin
        if (left_sum > dmax_ext) begin
            left_clamp = cfg.drive_max;
        end else if (left_sum < dmin_ext) begin
            left_clamp = cfg.drive_min;
        end else begin
            left_clamp = left_sum[DW-1:0];
        end
        if (right_sum > dmax_ext) begin
            right_clamp = cfg.drive_max;
        end else if (right_sum < dmin_ext) begin
            right_clamp = cfg.drive_min;
        end else begin
            right_clamp = right_sum[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[4]) begin
            r_left  <= left_clamp;
            r_right <= right_clamp;
            r_steer <= r_s4_steer;
            r_seen  <= r_s4_seen;
            r_stop  <= r_s4_stop;
        end
    end

    assign o_valid        = r_v[NS-1];
    assign o_left_drive   = r_left;
    assign o_right_drive  = r_right;
    assign o_steer_out    = r_steer;
    assign o_line_seen    = r_seen;
    assign o_stop_request = r_stop;

`ifndef SYNTHESIS
    // an empty input stage never pushes back
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> !o_stall)
        else $error("input stalled with empty input stage");

    // a stop result carries zero steer and no line
    a_stop_zero_steer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stop_request) |-> (o_steer_out == '0 && !o_line_seen))
        else $error("stop request with nonzero steer or line seen");

    // a beat that sees the line clears the lost count
    a_lost_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv[3] && r_s3_seen) |=> (r_lost_cnt == '0))
        else $error("lost count not cleared after line seen");
`endif

endmodule

// ===== hdl/lfspd_cfg_regs.sv =====
// Configuration register file for the steering PD core.
// Depends on lfspd_pkg for the register index codes and the t_cfg struct.
module lfspd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lfspd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lfspd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output lfspd_pkg::t_cfg                     o_cfg
);

    lfspd_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp          <= 12'sd461;
            r_cfg.kd          <= 12'sd0;
            r_cfg.base_drive  <= 16'sd1200;
            r_cfg.steer_limit <= 15'd1500;
            r_cfg.drive_max   <= 16'sd32767;
            r_cfg.drive_min   <= -16'sd32768;
            r_cfg.slew_step   <= 15'd75;
            r_cfg.lost_ticks  <= 16'd400;
        end else if (i_cfg_valid) begin
            case (lfspd_pkg::t_cfg_idx'(i_cfg_index))
                lfspd_pkg::CFG_KP:        r_cfg.kp          <= i_cfg_data[lfspd_pkg::GAIN_W-1:0];
                lfspd_pkg::CFG_KD:        r_cfg.kd          <= i_cfg_data[lfspd_pkg::GAIN_W-1:0];
                lfspd_pkg::CFG_BASE:      r_cfg.base_drive  <= i_cfg_data;
                lfspd_pkg::CFG_LIMIT:     r_cfg.steer_limit <= i_cfg_data[lfspd_pkg::LIM_W-1:0];
                lfspd_pkg::CFG_DRV_MAX:   r_cfg.drive_max   <= i_cfg_data;
                lfspd_pkg::CFG_DRV_MIN:   r_cfg.drive_min   <= i_cfg_data;
                lfspd_pkg::CFG_SLEW:      r_cfg.slew_step   <= i_cfg_data[lfspd_pkg::LIM_W-1:0];
                lfspd_pkg::CFG_LOST_TICK: r_cfg.lost_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule
